// ===== rtl/sbhm_pkg.sv =====
// package: sizes, codes and word types of the spatial block hash map
package sbhm_pkg;

  localparam int HASH_BUCKETS = 256;
  localparam int POOL_ENTRIES = 1024;
  localparam int COORD_BITS   = 16;

  localparam int BKT_W  = $clog2(HASH_BUCKETS);
  localparam int SLOT_W = $clog2(POOL_ENTRIES);
  localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
  localparam int KEY_W  = 3 * COORD_BITS;
  localparam int CLR_N  = (HASH_BUCKETS > POOL_ENTRIES) ? HASH_BUCKETS : POOL_ENTRIES;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam int Q_DEPTH = 2;
  localparam int Q_W     = $clog2(Q_DEPTH);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_GIVE   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_MISS     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_HEAD,
    BK_WALK,
    BK_FIN
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } command_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [10:0]       live_count;
  } result_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [BKT_W-1:0] bucket;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/sbhm_ram.sv =====
// generic single-port ram with registered read
module sbhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/sbhm_front.sv =====
// front: takes command words, hashes the coordinate and packs the key
module sbhm_front import sbhm_pkg::*; (
  input  logic      start,
  input  logic      busy,
  input  command_t  command,
  output logic      push,
  output item_t     item
);

  logic [31:0] sx, sy, sz, h;

  always_comb begin
    sx = {{(32-COORD_BITS){command.pos_x[COORD_BITS-1]}}, command.pos_x[COORD_BITS-1:0]};
    sy = {{(32-COORD_BITS){command.pos_y[COORD_BITS-1]}}, command.pos_y[COORD_BITS-1:0]};
    sz = {{(32-COORD_BITS){command.pos_z[COORD_BITS-1]}}, command.pos_z[COORD_BITS-1:0]};
    h  = sx + (sy << 3) + (sz << 6);
    item.cmd    = command.cmd;
    item.bucket = h[BKT_W-1:0];
    item.key    = {command.pos_z[COORD_BITS-1:0], command.pos_y[COORD_BITS-1:0],
                   command.pos_x[COORD_BITS-1:0]};
    push = start && !busy;
  end

endmodule

// ===== rtl/sbhm_queue.sv =====
// short queue of classified words between front and back
module sbhm_queue import sbhm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t stat
);

  item_t          store [Q_DEPTH];
  logic [Q_W-1:0] wr_ptr, rd_ptr;
  logic [Q_W:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (Q_W+1)'(push) - (Q_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_comb begin
    pop_item   = store[rd_ptr];
    stat.full  = (fill == (Q_W+1)'(Q_DEPTH));
    stat.empty = (fill == '0);
  end

endmodule

// ===== rtl/sbhm_back.sv =====
// back: clearing pass, chain walk and table updates
module sbhm_back import sbhm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    pop,
  output logic    init_busy,
  output logic    done,
  output result_t result
);

  bk_state_t state, state_next;

  logic [CLR_W-1:0]  cnt;
  logic [PTR_W-1:0]  total, cur, prev, hd, fnext;
  logic [SLOT_W-1:0] free_slot;
  logic              found;
  item_t             it;

  logic              head_we, coord_we, next_we, free_we;
  logic [BKT_W-1:0]  head_addr;
  logic [SLOT_W-1:0] ent_addr, free_addr;
  logic [PTR_W-1:0]  head_wdata, head_rdata, next_wdata, next_rdata;
  logic [KEY_W-1:0]  coord_rdata;
  logic [SLOT_W-1:0] free_wdata, free_rdata;
  logic              is_remove, is_give, can_give;
  result_t           res_next;

  sbhm_ram #(.WIDTH(PTR_W), .DEPTH(HASH_BUCKETS)) u_head (
    .clk, .we(head_we), .addr(head_addr), .wdata(head_wdata), .rdata(head_rdata));
  sbhm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_coord (
    .clk, .we(coord_we), .addr(ent_addr), .wdata(it.key), .rdata(coord_rdata));
  sbhm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_next (
    .clk, .we(next_we), .addr(ent_addr), .wdata(next_wdata), .rdata(next_rdata));
  sbhm_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_ENTRIES)) u_free (
    .clk, .we(free_we), .addr(free_addr), .wdata(free_wdata), .rdata(free_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    head_we    = 1'b0;
    coord_we   = 1'b0;
    next_we    = 1'b0;
    free_we    = 1'b0;
    head_addr  = it.bucket;
    head_wdata = NIL;
    ent_addr   = cur[SLOT_W-1:0];
    next_wdata = fnext;
    free_addr  = total[SLOT_W-1:0];
    free_wdata = cur[SLOT_W-1:0];
    is_remove  = (it.cmd == CMD_REMOVE);
    is_give    = (it.cmd == CMD_GIVE);
    can_give   = (total < PTR_W'(POOL_ENTRIES));
    res_next   = '0;
    res_next.live_count = 11'(total);
    case (state)
      BK_INIT: begin
        head_addr  = cnt[BKT_W-1:0];
        head_we    = ({1'b0, cnt} < (CLR_W+1)'(HASH_BUCKETS));
        free_addr  = cnt[SLOT_W-1:0];
        free_wdata = cnt[SLOT_W-1:0];
        free_we    = ({1'b0, cnt} < (CLR_W+1)'(POOL_ENTRIES));
        if (cnt == CLR_W'(CLR_N - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        head_addr = q_item.bucket;
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_HEAD;
        end
      end
      BK_HEAD: begin
        ent_addr = head_rdata[SLOT_W-1:0];
        state_next = (head_rdata == NIL) ? BK_FIN : BK_WALK;
      end
      BK_WALK: begin
        ent_addr = next_rdata[SLOT_W-1:0];
        if (coord_rdata == it.key || next_rdata == NIL) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        state_next = BK_IDLE;
        if (is_remove) begin
          if (found) begin
            if (prev == NIL) begin
              head_we    = 1'b1;
              head_wdata = fnext;
            end else begin
              next_we  = 1'b1;
              ent_addr = prev[SLOT_W-1:0];
            end
            free_we    = 1'b1;
            free_addr  = SLOT_W'(total - 1'b1);
            res_next.status     = ST_REMOVED;
            res_next.slot       = cur[SLOT_W-1:0];
            res_next.live_count = 11'(total - 1'b1);
          end else begin
            res_next.status = ST_MISS;
          end
        end else if (found) begin
          res_next.status = ST_HIT;
          res_next.slot   = cur[SLOT_W-1:0];
        end else if (!is_give) begin
          res_next.status = ST_MISS;
        end else if (!can_give) begin
          res_next.status = ST_FULL;
        end else begin
          ent_addr   = free_slot;
          coord_we   = 1'b1;
          next_we    = 1'b1;
          next_wdata = hd;
          head_we    = 1'b1;
          head_wdata = PTR_W'(free_slot);
          res_next.status     = ST_INSERTED;
          res_next.slot       = free_slot;
          res_next.live_count = 11'(total + 1'b1);
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == BK_FIN);
      if (state == BK_INIT) begin
        cnt <= cnt + 1'b1;
      end
      if (state == BK_FIN) begin
        total <= PTR_W'(res_next.live_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it <= q_item;
    end
    case (state)
      BK_HEAD: begin
        cur       <= head_rdata;
        hd        <= head_rdata;
        prev      <= NIL;
        found     <= 1'b0;
        free_slot <= free_rdata;
      end
      BK_WALK: begin
        if (coord_rdata == it.key) begin
          found <= 1'b1;
          fnext <= next_rdata;
        end else begin
          prev <= cur;
          cur  <= next_rdata;
        end
      end
      default: ;
    endcase
    if (state == BK_FIN) begin
      result <= res_next;
    end
  end

  assign init_busy = (state == BK_INIT);

endmodule

// ===== rtl/spatial_block_hash_map.sv =====
// top level: spatial block hash map
// after reset the block runs a clearing pass over its 256 bucket heads and 1024 free-list entries with busy high.
// a command is then popped, its bucket head read and its chain walked in the back end,
// comparing one chain entry per cycle through the entry ram read port; a two-word
// queue lets start be taken while the back end works. each result shows on
// result for one cycle with done high and must be taken then.
module spatial_block_hash_map import sbhm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  command_t command,
  output logic     done,
  output result_t  result
);

  logic      push, pop, init_busy;
  item_t     push_item, pop_item;
  q_status_t qs;

  assign busy = qs.full || init_busy;

  sbhm_front u_front (
    .start, .busy, .command, .push, .item(push_item));

  sbhm_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .pop_item, .stat(qs));

  sbhm_back u_back (
    .clk, .rst, .q_empty(qs.empty), .q_item(pop_item), .pop, .init_busy,
    .done, .result);

endmodule

// ===== rtl/sbhm_checker.sv =====
// checker: port-level properties of the hash map, bound to the top level
module sbhm_checker import sbhm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    done,
  input result_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  a_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result words back to back");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_MISS || result.status == ST_FULL)) |-> result.slot == '0)
    else $error("miss or full with non-zero slot");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> result.live_count == 11'(POOL_ENTRIES))
    else $error("pool full with free slots left");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_INSERTED) |-> result.live_count != '0)
    else $error("insert leaves map empty");

endmodule

bind spatial_block_hash_map sbhm_checker u_sbhm_checker (
  .clk, .rst, .done, .result);

// ===== sim/spatial_block_hash_map_tb.sv =====
// testbench: spatial block hash map against its own chained map predictor
module spatial_block_hash_map_tb;
  import sbhm_pkg::*;

  localparam int LIMIT = 2000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  command_t command = '0;
  logic     done;
  result_t  result;

  spatial_block_hash_map dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [PTR_W-1:0]  head_of [HASH_BUCKETS];
  logic [KEY_W-1:0]  key_of [POOL_ENTRIES];
  logic [PTR_W-1:0]  link_of [POOL_ENTRIES];
  logic [SLOT_W-1:0] spare_slots [POOL_ENTRIES];
  int unsigned       held;

  result_t   awaited [$];
  int        bad;
  int        cycle;
  int        idle_pct;
  logic [KEY_W-1:0] known [$];

  function automatic logic [BKT_W-1:0] bucket_for(logic signed [15:0] x,
                                                  logic signed [15:0] y,
                                                  logic signed [15:0] z);
    logic [31:0] h;
    h = 32'(signed'(x)) + (32'(signed'(y)) << 3) + (32'(signed'(z)) << 6);
    return h[BKT_W-1:0];
  endfunction

  function automatic result_t predict_map(command_t c);
    logic [BKT_W-1:0] b;
    logic [KEY_W-1:0] k;
    logic [PTR_W-1:0] cur, prev, hit;
    int               steps;
    result_t          r;
    b = bucket_for(c.pos_x, c.pos_y, c.pos_z);
    k = {c.pos_z, c.pos_y, c.pos_x};
    cur = head_of[b];
    prev = NIL;
    hit = NIL;
    steps = 0;
    r = '0;
    while (cur < NIL && steps < POOL_ENTRIES) begin
      if (key_of[cur[SLOT_W-1:0]] == k) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = link_of[cur[SLOT_W-1:0]];
      steps++;
    end
    if (c.cmd == CMD_REMOVE) begin
      if (hit == NIL) r.status = ST_MISS;
      else begin
        if (prev == NIL) head_of[b] = link_of[hit[SLOT_W-1:0]];
        else link_of[prev[SLOT_W-1:0]] = link_of[hit[SLOT_W-1:0]];
        if (held > 0) begin
          held--;
          spare_slots[held] = hit[SLOT_W-1:0];
        end
        r.status = ST_REMOVED;
        r.slot = hit[SLOT_W-1:0];
      end
    end else if (hit != NIL) begin
      r.status = ST_HIT;
      r.slot = hit[SLOT_W-1:0];
    end else if (c.cmd != CMD_GIVE) begin
      r.status = ST_MISS;
    end else if (held >= POOL_ENTRIES) begin
      r.status = ST_FULL;
    end else begin
      logic [SLOT_W-1:0] s;
      s = spare_slots[held];
      held++;
      key_of[s] = k;
      link_of[s] = head_of[b];
      head_of[b] = {1'b0, s};
      r.status = ST_INSERTED;
      r.slot = s;
    end
    r.live_count = 11'(held);
    return r;
  endfunction

  task automatic send_word(logic [1:0] op, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    command_t c;
    c.cmd = op;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    awaited.push_back(predict_map(c));
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected word %h", result);
      end else begin
        result_t e;
        e = awaited.pop_front();
        if (e !== result) begin
          bad++;
          if (bad <= 10)
            $display("mismatch: expected st %0d slot %0d cnt %0d, got st %0d slot %0d cnt %0d",
                     e.status, e.slot, e.live_count,
                     result.status, result.slot, result.live_count);
        end
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return -16'($urandom_range(8));
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(CMD_FIND, 0, 0, 0);
    send_word(CMD_REMOVE, 0, 0, 0);
    send_word(CMD_GIVE, 0, 0, 0);
    send_word(CMD_GIVE, 0, 0, 0);
    send_word(CMD_FIND, 0, 0, 0);
    send_word(CMD_SPARE, 0, 0, 0);
    send_word(CMD_SPARE, 1, 2, 3);
    send_word(CMD_GIVE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(CMD_GIVE, -16'sh8000, -16'sh8000, -16'sh8000);
    send_word(CMD_GIVE, -16'sd1, -16'sd1, -16'sd1);
    // same bucket: x+8y collide; (0,0,4) wraps onto the bucket of (0,0,0)
    send_word(CMD_GIVE, 8, 0, 0);
    send_word(CMD_GIVE, 0, 1, 0);
    send_word(CMD_GIVE, 0, 0, 4);
    send_word(CMD_REMOVE, 0, 1, 0);
    send_word(CMD_FIND, 8, 0, 0);
    send_word(CMD_FIND, 0, 0, 4);
    send_word(CMD_REMOVE, 0, 0, 4);
    send_word(CMD_REMOVE, 8, 0, 0);
    send_word(CMD_REMOVE, 0, 0, 0);
    send_word(CMD_FIND, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      logic [1:0] op;
      logic [15:0] x, y, z;
      op = 2'($urandom_range(99) < 45 ? CMD_GIVE :
                $urandom_range(1) ? CMD_REMOVE :
                $urandom_range(9) == 0 ? CMD_SPARE : CMD_FIND);
      if (known.size() != 0 && $urandom_range(99) < 60)
        {z, y, x} = known[$urandom_range(known.size() - 1)];
      else begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        if (known.size() < 300) known.push_back({z, y, x});
      end
      send_word(op, x, y, z);
    end
    drain();
  endtask

  // fill the pool past full, then free a few slots
  task automatic test_full_pool();
    idle_pct = 0;
    for (int i = 0; i < POOL_ENTRIES + 4; i++)
      send_word(CMD_GIVE, 16'(i), 16'(i >> 3), 16'sh4000);
    for (int i = 0; i < 10; i++)
      send_word(CMD_REMOVE, 16'(i), 16'(i >> 3), 16'sh4000);
    drain();
  endtask

  initial begin
    bad = 0;
    cycle = 0;
    idle_pct = 0;
    for (int i = 0; i < HASH_BUCKETS; i++) head_of[i] = NIL;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      key_of[i] = '0;
      link_of[i] = NIL;
      spare_slots[i] = SLOT_W'(i);
    end
    held = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    idle_pct = 0;
    test_random(200);
    idle_pct = 46;
    test_random(200);
    idle_pct = 13;
    test_random(200);
    idle_pct = 0;
    test_random(200);
    test_full_pool();
    repeat (40) @(posedge clk);
    if (bad == 0 && awaited.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
